// ----- rtl/w2ba_pkg.sv -----
// Shared types and constants for the weighted 2-D bin accumulator.
// Field widths, operation codes, register indexes and controller states.
// No dependencies.
`default_nettype none

package w2ba_pkg;

  // Field widths
  localparam int COORD_W    = 24;
  localparam int HALF_W     = 23;
  localparam int CNT_W      = 7;
  localparam int POWER_W    = 32;
  localparam int BIN_W      = 12;
  localparam int SUM_W      = 48;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Stream widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 160;

  // Arithmetic widths
  localparam int OFF_W       = COORD_W;        // u + hw, in [0, 2hw]
  localparam int DIVD_W      = OFF_W + CNT_W;  // (u + hw) * cols
  localparam int CALC_ADDR_W = 2 * CNT_W;      // row * cols + col
  localparam int DIV_STEPS   = CNT_W;          // one quotient bit per step
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0]  SUM_MAX        = '1;
  localparam logic [HALF_W-1:0] HALF_RESET     = HALF_W'(65536);
  localparam logic [CNT_W-1:0]  COUNT_RESET    = CNT_W'(64);

  // Operation codes carried in the input kind field
  typedef enum logic [OP_W-1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN_U = 2'd0,
    CFG_SPAN_V = 2'd1,
    CFG_COLS   = 2'd2,
    CFG_ROWS   = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_UPD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/weighted_2d_bin_accumulator_top.sv -----
// Weighted 2-D bin accumulator: power histogram over a rectangular receiver.
// Depends on w2ba_pkg and w2ba_ram (bin sums held in one synchronous RAM).
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------------
//  s_*     | in        | s_tvalid / s_tready | tuser op; tdata u, v, power, read_bin
//  m_*     | out       | m_tvalid / m_tready | tuser accepted; tdata addr, sum, total, peak
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// A deposit passes through capture, range check and multiply, seven steps of
// the restoring divider (both axes in parallel), address, RAM read, update.
// A read passes through capture, RAM read and update; a clear zeroes one RAM
// entry per cycle and then replies. After reset the same clearing pass runs over
// all MAX_COLS*MAX_ROWS entries (4096 by default) with s_tready low; cfg is always
// taken. A result waits in the output register while the next item is taken;
// the update step stalls only if that register is still full.
`default_nettype none

module weighted_2d_bin_accumulator_top import w2ba_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_u[23:0], coord_v[47:24],
                                           // hit_power[79:48], read_bin[91:80]
  input  logic [OP_W-1:0]       s_tuser,   // op[1:0]
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // bin_address[11:0], bin_sum[59:12],
                                           // total_power[107:60], peak_bin_sum[155:108]
  output logic                  m_tuser,   // accepted[0]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BIN_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW        = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [HALF_W-1:0] span_u;
  logic [HALF_W-1:0] span_v;
  logic [CNT_W-1:0]  cols_in_use;
  logic [CNT_W-1:0]  rows_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_u      <= HALF_RESET;
      span_v      <= HALF_RESET;
      cols_in_use <= COUNT_RESET;
      rows_in_use <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SPAN_U: span_u      <= cfg_data[HALF_W-1:0];
        CFG_SPAN_V: span_v      <= cfg_data[HALF_W-1:0];
        CFG_COLS:   cols_in_use <= cfg_data[CNT_W-1:0];
        CFG_ROWS:   rows_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  state_t state, state_next;

  logic [OP_W-1:0]           op_q;
  logic signed [COORD_W-1:0] u_q;
  logic signed [COORD_W-1:0] v_q;
  logic [POWER_W-1:0]        power_q;
  logic [CALC_ADDR_W-1:0]    bin_addr;
  logic [CNT_W-1:0]          nc_q, nr_q;
  logic [DIVD_W-1:0]         rem_u, rem_v;
  logic [DIVD_W-1:0]         sd_u, sd_v;
  logic [CNT_W-1:0]          q_u, q_v;
  logic [STEP_W-1:0]         step;
  logic [AW-1:0]             clear_pointer;
  logic                      sweep_reply;
  logic [SUM_W-1:0]          running_total;
  logic [SUM_W-1:0]          running_peak;

  // Output register
  logic              o_accepted;
  logic [BIN_W-1:0]  o_addr;
  logic [SUM_W-1:0]  o_sum;
  logic [SUM_W-1:0]  o_total;
  logic [SUM_W-1:0]  o_peak;

  // RAM port signals
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic [SUM_W-1:0]  rd_data;

  logic in_accept, out_free, out_load;

  // ---------------------------------------------------------------------------
  // Range check, offsets and dividends (PREP)
  logic [HALF_W-1:0]  hw_eff, hh_eff;
  logic [COORD_W-1:0] au, av;
  logic               in_range;
  logic [COORD_W:0]   sum_u, sum_v;
  logic [OFF_W-1:0]   off_u, off_v;
  logic [CNT_W-1:0]   nc_c, nr_c;
  logic [DIVD_W-1:0]  dvd_u, dvd_v;
  logic [DIVD_W-1:0]  sd_u_init, sd_v_init;

  always_comb begin
    hw_eff   = (span_u == '0) ? HALF_W'(1) : span_u;
    hh_eff   = (span_v == '0) ? HALF_W'(1) : span_v;
    au       = u_q[COORD_W-1] ? COORD_W'(-u_q) : COORD_W'(u_q);
    av       = v_q[COORD_W-1] ? COORD_W'(-v_q) : COORD_W'(v_q);
    in_range = (au <= {1'b0, hw_eff}) && (av <= {1'b0, hh_eff});
    sum_u    = {u_q[COORD_W-1], u_q} + {2'b00, hw_eff};
    sum_v    = {v_q[COORD_W-1], v_q} + {2'b00, hh_eff};
    off_u    = sum_u[OFF_W-1:0];
    off_v    = sum_v[OFF_W-1:0];

    if (cols_in_use == '0) begin
      nc_c = CNT_W'(1);
    end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
      nc_c = CNT_W'(MAX_COLS);
    end else begin
      nc_c = cols_in_use;
    end
    if (rows_in_use == '0) begin
      nr_c = CNT_W'(1);
    end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
      nr_c = CNT_W'(MAX_ROWS);
    end else begin
      nr_c = rows_in_use;
    end

    dvd_u     = DIVD_W'(off_u) * DIVD_W'(nc_c);
    dvd_v     = DIVD_W'(off_v) * DIVD_W'(nr_c);
    // divisor 2h aligned to the top quotient bit
    sd_u_init = DIVD_W'({hw_eff, 1'b0}) << (DIV_STEPS - 1);
    sd_v_init = DIVD_W'({hh_eff, 1'b0}) << (DIV_STEPS - 1);
  end

  // ---------------------------------------------------------------------------
  // Divider step and bin address
  logic              ge_u, ge_v;
  logic [CNT_W-1:0]  col, row;
  logic [CALC_ADDR_W-1:0] bin_calc;

  always_comb begin
    ge_u     = rem_u >= sd_u;
    ge_v     = rem_v >= sd_v;
    col      = (q_u >= nc_q) ? nc_q - CNT_W'(1) : q_u;
    row      = (q_v >= nr_q) ? nr_q - CNT_W'(1) : q_v;
    bin_calc = CALC_ADDR_W'(row) * CALC_ADDR_W'(nc_q) + CALC_ADDR_W'(col);
  end

  // ---------------------------------------------------------------------------
  // Saturating updates (UPD)
  logic [SUM_W:0]   bin_wide, total_wide;
  logic [SUM_W-1:0] new_sum, new_total, new_peak;
  logic             in_mem;

  always_comb begin
    bin_wide   = {1'b0, rd_data} + (SUM_W + 1)'(power_q);
    total_wide = {1'b0, running_total} + (SUM_W + 1)'(power_q);
    new_sum    = bin_wide[SUM_W] ? SUM_MAX : bin_wide[SUM_W-1:0];
    new_total  = total_wide[SUM_W] ? SUM_MAX : total_wide[SUM_W-1:0];
    new_peak   = (new_sum > running_peak) ? new_sum : running_peak;
    in_mem     = 32'(bin_addr) < 32'(BIN_COUNT);
  end

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (clear_pointer == LAST_BIN) begin
          state_next = sweep_reply ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (s_tuser)
            OP_DEPOSIT: state_next = ST_PREP;
            OP_READ:    state_next = ST_READ;
            OP_CLEAR:   state_next = ST_SWEEP;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_PREP: state_next = in_range ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    in_accept = s_tvalid && s_tready;
    out_free  = !m_tvalid || m_tready;
    out_load  = ((state == ST_UPD) || (state == ST_EMIT)) && out_free;
    rd_en     = (state == ST_READ);
    wr_en     = (state == ST_SWEEP) ||
                ((state == ST_UPD) && out_free && (op_q == OP_DEPOSIT));
    wr_addr   = (state == ST_SWEEP) ? clear_pointer : AW'(bin_addr);
    wr_data   = (state == ST_SWEEP) ? '0 : new_sum;
  end

  // ---------------------------------------------------------------------------
  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      clear_pointer <= '0;
      sweep_reply   <= 1'b0;
      running_total <= '0;
      running_peak  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      // clearing pass pointer
      if (state == ST_SWEEP) begin
        clear_pointer <= (clear_pointer == LAST_BIN) ? '0 : clear_pointer + AW'(1);
      end

      // a clear zeroes the totals at once and replies after the pass
      if (in_accept) begin
        sweep_reply <= (s_tuser == OP_CLEAR);
        if (s_tuser == OP_CLEAR) begin
          running_total <= '0;
          running_peak  <= '0;
        end
      end

      if ((state == ST_UPD) && out_free && (op_q == OP_DEPOSIT)) begin
        running_total <= new_total;
        running_peak  <= new_peak;
      end

      // output register valid
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op_q     <= s_tuser;
          u_q      <= s_tdata[23:0];
          v_q      <= s_tdata[47:24];
          power_q  <= s_tdata[79:48];
          bin_addr <= CALC_ADDR_W'(s_tdata[91:80]);
        end
      end
      ST_PREP: begin
        nc_q  <= nc_c;
        nr_q  <= nr_c;
        rem_u <= dvd_u;
        rem_v <= dvd_v;
        sd_u  <= sd_u_init;
        sd_v  <= sd_v_init;
        q_u   <= '0;
        q_v   <= '0;
        step  <= STEP_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        // one restoring step per axis
        if (ge_u) begin
          rem_u <= rem_u - sd_u;
        end
        if (ge_v) begin
          rem_v <= rem_v - sd_v;
        end
        q_u  <= {q_u[CNT_W-2:0], ge_u};
        q_v  <= {q_v[CNT_W-2:0], ge_v};
        sd_u <= sd_u >> 1;
        sd_v <= sd_v >> 1;
        step <= step - STEP_W'(1);
      end
      ST_ADDR: bin_addr <= bin_calc;
      ST_UPD: begin
        if (out_free) begin
          o_addr <= bin_addr[BIN_W-1:0];
          if (op_q == OP_DEPOSIT) begin
            o_accepted <= 1'b1;
            o_sum      <= new_sum;
            o_total    <= new_total;
            o_peak     <= new_peak;
          end else begin
            o_accepted <= 1'b0;
            o_sum      <= in_mem ? rd_data : '0;
            o_total    <= running_total;
            o_peak     <= running_peak;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          o_accepted <= 1'b0;
          o_addr     <= '0;
          o_sum      <= '0;
          o_total    <= running_total;
          o_peak     <= running_peak;
        end
      end
      default: ;
    endcase
  end

  assign m_tuser = o_accepted;
  assign m_tdata = {4'b0000, o_peak, o_total, o_sum, o_addr};

  // ---------------------------------------------------------------------------
  // Bin sum memory
  w2ba_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BIN_COUNT),
    .ADDR_W(AW)
  ) u_bins (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(AW'(bin_addr)),
    .rd_data(rd_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  a_peak_within_total: assert property (@(posedge clk) disable iff (rst)
    running_peak <= running_total)
    else $error("peak bin sum exceeds running total");

  a_landed_sum_within_peak: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (o_sum <= o_peak))
    else $error("landed deposit reports a bin sum above the peak");

  a_write_only_sweep_or_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == ST_SWEEP) || (state == ST_UPD)))
    else $error("bin memory written outside clearing pass or update");

  a_no_input_during_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |=> ((state == ST_SWEEP) || !$past(in_accept)))
    else $error("input transaction taken during clearing pass");

endmodule

`default_nettype wire

// ----- rtl/w2ba_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is requested.
// No dependencies.
`default_nettype none

module w2ba_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
